/* rtl/assert_macros.svh */
// Assertion macros shared by the checker files of this block.
// Each macro expects aclk and aresetn to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define V8D_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define V8D_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked across reset.
`define V8D_ASSERT_RST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/v8d_pkg.sv */
// Shared types and constants for the eight-direction quantizer.
// Used by the sector, pick and top-level modules; depends on nothing.
package v8d_pkg;

    localparam int COORD_BITS = 16;
    localparam int MAG_W      = COORD_BITS;
    localparam int FRAC_W     = 16;
    localparam int TAN_W      = 18;
    localparam int PROD_W     = MAG_W + TAN_W;
    localparam int N_EDGES    = 6;
    localparam int K_W        = 3;

    // Band edge tangents at 15, 22.5, 30, 60, 67.5 and 75 degrees, 16 fraction bits.
    localparam logic [TAN_W-1:0] EDGE_TAN [N_EDGES] = '{
        18'd17560, 18'd27146, 18'd37837, 18'd113512, 18'd158218, 18'd244584
    };

    typedef enum logic [2:0] {
        DIR_R  = 3'd0,
        DIR_RD = 3'd1,
        DIR_D  = 3'd2,
        DIR_LD = 3'd3,
        DIR_L  = 3'd4,
        DIR_LU = 3'd5,
        DIR_U  = 3'd6,
        DIR_RU = 3'd7
    } dir_t;

    // Result of the angle classification for one item.
    typedef struct packed {
        logic           y_zero;
        logic           x_neg;
        logic           y_neg;
        logic [K_W-1:0] edge_cnt;
        dir_t           prev;
    } sector_t;

endpackage

/* rtl/v8d_sector.sv */
// Angle classification: magnitudes, six tangent compares and the edge count.
// Depends on v8d_pkg.
module v8d_sector
    import v8d_pkg::*;
(
    input  logic signed [COORD_BITS-1:0] vec_x,
    input  logic signed [COORD_BITS-1:0] vec_y,
    input  logic        [2:0]            prev_dir,
    output sector_t                      sector
);

    logic [MAG_W-1:0]   ax;
    logic [MAG_W-1:0]   ay;
    logic [PROD_W-1:0]  ay_scaled;
    logic [N_EDGES-1:0] at_or_beyond;
    logic [K_W-1:0]     cnt;

    // The most negative input maps to 2^(COORD_BITS-1), which still fits unsigned.
    assign ax = vec_x[COORD_BITS-1] ? MAG_W'(~vec_x + 1'b1) : MAG_W'(vec_x);
    assign ay = vec_y[COORD_BITS-1] ? MAG_W'(~vec_y + 1'b1) : MAG_W'(vec_y);
    assign ay_scaled = PROD_W'(ay) << FRAC_W;

    always_comb begin
        for (int i = 0; i < N_EDGES; i++) begin
            // A tie on an edge counts as lying beyond it.
            at_or_beyond[i] = ay_scaled >= (PROD_W'(ax) * PROD_W'(EDGE_TAN[i]));
        end
    end

    always_comb begin
        cnt = '0;
        for (int i = 0; i < N_EDGES; i++) begin
            cnt = cnt + K_W'(at_or_beyond[i]);
        end
    end

    assign sector.y_zero   = (vec_y == '0);
    assign sector.x_neg    = vec_x[COORD_BITS-1];
    assign sector.y_neg    = vec_y[COORD_BITS-1];
    assign sector.edge_cnt = cnt;
    assign sector.prev     = dir_t'(prev_dir);

endmodule

/* rtl/v8d_pick.sv */
// Direction choice from a classified sector, with sticky flank bands.
// Depends on v8d_pkg.
module v8d_pick
    import v8d_pkg::*;
(
    input  sector_t sector,
    output dir_t    dir
);

    dir_t horiz;
    dir_t diag;
    dir_t vert;

    assign horiz = sector.x_neg ? DIR_L : DIR_R;
    assign vert  = sector.y_neg ? DIR_U : DIR_D;
    assign diag  = sector.y_neg ? (sector.x_neg ? DIR_LU : DIR_RU)
                                : (sector.x_neg ? DIR_LD : DIR_RD);

    always_comb begin
        if (sector.y_zero) begin
            dir = horiz;
        end else begin
            case (sector.edge_cnt)
                3'd0: dir = horiz;
                3'd1, 3'd2: begin
                    // Between horizontal and diagonal: keep either neighbor.
                    if (sector.prev == horiz || sector.prev == diag) begin
                        dir = sector.prev;
                    end else begin
                        dir = (sector.edge_cnt == 3'd2) ? diag : horiz;
                    end
                end
                3'd3: dir = diag;
                3'd4, 3'd5: begin
                    // Between diagonal and vertical: keep either neighbor.
                    if (sector.prev == diag || sector.prev == vert) begin
                        dir = sector.prev;
                    end else begin
                        dir = (sector.edge_cnt == 3'd5) ? vert : diag;
                    end
                end
                default: dir = vert;
            endcase
        end
    end

endmodule

/* rtl/vector_to_eight_direction_hysteresis_top.sv */
// Top level of the eight-direction quantizer with hysteresis.
// Depends on v8d_pkg, v8d_sector and v8d_pick.
//
// Usage: each input item carries a signed vector (vec_x to the right, vec_y
// toward the screen bottom) and the direction reported for the previous item.
// The block returns one item per input item with the chosen direction, coded
// 0 R, 1 RD, 2 D, 3 LD, 4 L, 5 LU, 6 U, 7 RU. The zero vector gives R.
// The input channel is s_tvalid/s_tready/s_tdata and the result channel is
// m_tvalid/m_tready/m_tdata; an item moves at a clock edge where valid and
// ready are both high. Results leave in the order the items arrived.
// The datapath has three register stages: an input register, a register after
// the tangent compares, and the result register. With m_tready held high an
// accepted item passes through all three registers to m_tvalid, and one item is
// taken every cycle. The compare stage (six constant multiplies and compares)
// sets the clock period.
// When the receiver stalls, the result register holds its item and the
// earlier stages keep filling until all three hold an item; s_tready then
// drops until m_tready returns. A synchronous low level on aresetn empties all
// stages; m_tvalid is low in the cycle after reset.
module vector_to_eight_direction_hysteresis_top
    import v8d_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata, lowest bit first: vec_x[15:0], vec_y[31:16], prev_dir[34:32], zeros.
    input  logic [39:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata, lowest bit first: dir_out[2:0], zeros.
    output logic [7:0]  m_tdata
);

    localparam int X_LO = 0;
    localparam int Y_LO = COORD_BITS;
    localparam int P_LO = 2 * COORD_BITS;

    // Stage 1: input register.
    logic                         in_valid_reg, in_valid_next;
    logic signed [COORD_BITS-1:0] in_x_reg, in_x_next;
    logic signed [COORD_BITS-1:0] in_y_reg, in_y_next;
    logic [2:0]                   in_prev_reg, in_prev_next;

    // Stage 2: classified sector.
    logic    sec_valid_reg, sec_valid_next;
    sector_t sec_reg, sec_next;

    // Stage 3: result register.
    logic out_valid_reg, out_valid_next;
    dir_t out_dir_reg, out_dir_next;

    logic    in_ready;
    logic    sec_ready;
    logic    out_ready;
    sector_t sec_comb;
    dir_t    dir_comb;

    // A stage can load when it is empty or its item moves on this cycle.
    assign out_ready = !out_valid_reg || m_tready;
    assign sec_ready = !sec_valid_reg || out_ready;
    assign in_ready  = !in_valid_reg  || sec_ready;

    v8d_sector u_sector (
        .vec_x    (in_x_reg),
        .vec_y    (in_y_reg),
        .prev_dir (in_prev_reg),
        .sector   (sec_comb)
    );

    v8d_pick u_pick (
        .sector (sec_reg),
        .dir    (dir_comb)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        in_x_next     = in_x_reg;
        in_y_next     = in_y_reg;
        in_prev_next  = in_prev_reg;
        if (in_ready) begin
            in_valid_next = s_tvalid;
            in_x_next     = s_tdata[X_LO +: COORD_BITS];
            in_y_next     = s_tdata[Y_LO +: COORD_BITS];
            in_prev_next  = s_tdata[P_LO +: 3];
        end
    end

    always_comb begin
        sec_valid_next = sec_valid_reg;
        sec_next       = sec_reg;
        if (sec_ready) begin
            sec_valid_next = in_valid_reg;
            sec_next       = sec_comb;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        out_dir_next   = out_dir_reg;
        if (out_ready) begin
            out_valid_next = sec_valid_reg;
            out_dir_next   = dir_comb;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            sec_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            sec_valid_reg <= sec_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_x_reg    <= in_x_next;
        in_y_reg    <= in_y_next;
        in_prev_reg <= in_prev_next;
        sec_reg     <= sec_next;
        out_dir_reg <= out_dir_next;
    end

    assign s_tready = in_ready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_dir_reg};

endmodule

/* rtl/v8d_checker.sv */
// Port-level checks for the eight-direction quantizer, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module v8d_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    // A stalled result keeps its value until it is taken.
    `V8D_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

    // Only the three direction bits may be set.
    `V8D_ASSERT_IMP(a_pad_zero, m_tvalid, m_tdata[7:3] == 5'd0, "result padding not zero")

    // With the receiver ready, every stage advances, so an item can be taken.
    `V8D_ASSERT_IMP(a_no_block, m_tready, s_tready, "input blocked while output drains")

    // Reset empties the pipeline.
    `V8D_ASSERT_RST(a_reset_empty, !aresetn, !m_tvalid, "result valid after reset")

endmodule

bind vector_to_eight_direction_hysteresis_top v8d_checker u_v8d_checker (.*);

/* sim/v8d_direction_checker.sv */
// Scoreboard for the eight-direction quantizer: watches both stream channels,
// predicts the direction of every accepted vector and compares results in order.
// Depends on v8d_pkg for the direction encoding.
module v8d_direction_checker
    import v8d_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    // s_tdata, lowest bit first: vec_x[15:0], vec_y[31:16], prev_dir[34:32], zeros.
    input  logic [39:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata, lowest bit first: dir_out[2:0], zeros.
    input  logic [7:0]  m_tdata,
    output int          outstanding,
    output int          fail_count
);

    typedef struct {
        logic [15:0] vec_x;
        logic [15:0] vec_y;
        dir_t        prev;
        dir_t        heading;
    } heading_t;

    heading_t expected_headings[$];
    int       mismatches = 0;

    assign fail_count = mismatches;

    function automatic dir_t predict_direction(logic [15:0] raw_x, logic [15:0] raw_y,
                                               dir_t prev);
        logic [16:0]     mag_x;
        logic [16:0]     mag_y;
        longint unsigned tan_q16;
        logic            x_neg;
        logic            y_neg;
        int              edges_passed;
        dir_t            horiz;
        dir_t            diag;
        dir_t            vert;
        x_neg = raw_x[15];
        y_neg = raw_y[15];
        mag_x = x_neg ? 17'(17'd65536 - 17'(raw_x)) : 17'(raw_x);
        mag_y = y_neg ? 17'(17'd65536 - 17'(raw_y)) : 17'(raw_y);
        horiz = x_neg ? DIR_L : DIR_R;
        if (mag_y == 0)
            return horiz;

        // Count the band edges that the angle sits on or beyond.
        edges_passed = 0;
        for (int i = 0; i < 6; i++) begin
            case (i)
                0: tan_q16 = 17560;
                1: tan_q16 = 27146;
                2: tan_q16 = 37837;
                3: tan_q16 = 113512;
                4: tan_q16 = 158218;
                default: tan_q16 = 244584;
            endcase
            if ((64'(mag_y) << 16) >= 64'(mag_x) * tan_q16)
                edges_passed++;
        end

        if (y_neg) begin
            vert = DIR_U;
            diag = x_neg ? DIR_LU : DIR_RU;
        end else begin
            vert = DIR_D;
            diag = x_neg ? DIR_LD : DIR_RD;
        end

        // The two flanking bands keep a neighboring previous direction.
        case (edges_passed)
            0: return horiz;
            1, 2: begin
                if (prev == horiz || prev == diag)
                    return prev;
                return (edges_passed == 2) ? diag : horiz;
            end
            3: return diag;
            4, 5: begin
                if (prev == diag || prev == vert)
                    return prev;
                return (edges_passed == 5) ? vert : diag;
            end
            default: return vert;
        endcase
    endfunction

    always @(posedge aclk) begin : monitor
        heading_t want;
        logic [2:0] got;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                want.vec_x   = s_tdata[15:0];
                want.vec_y   = s_tdata[31:16];
                want.prev    = dir_t'(s_tdata[34:32]);
                want.heading = predict_direction(want.vec_x, want.vec_y, want.prev);
                expected_headings.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata[2:0];
                if (expected_headings.size() == 0) begin
                    $display("%0t: unexpected result item: expected none, actual dir_out %b",
                             $time, got);
                    mismatches++;
                end else begin
                    want = expected_headings.pop_front();
                    if (got !== want.heading) begin
                        $display({"%0t: dir_out mismatch for x=%0d y=%0d prev=%0d: ",
                                  "expected %0d, actual %b"},
                                 $time, $signed(want.vec_x), $signed(want.vec_y),
                                 want.prev, want.heading, got);
                        mismatches++;
                    end
                end
            end
        end
        outstanding <= expected_headings.size();
    end

endmodule

/* sim/vector_to_eight_direction_hysteresis_top_test.sv */
// Testbench top for the eight-direction quantizer: clock, reset, stimulus and verdict.
// Depends on v8d_pkg, the block vector_to_eight_direction_hysteresis_top and the
// scoreboard v8d_direction_checker, which does all prediction and comparison.
module vector_to_eight_direction_hysteresis_top_test;
    import v8d_pkg::*;

    // The block has three register stages, so the settle wait after the
    // last expected result is long enough to catch any stray extra item.
    localparam int SETTLE_CYCLES    = 8;
    localparam int RANDOM_PER_PHASE = 275;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;

    int outstanding;
    int fail_count;

    // Percentages of cycles in which the sender idles and the receiver stalls.
    int send_idle_pct = 0;
    int stall_pct     = 0;

    always #5 aclk = ~aclk;

    vector_to_eight_direction_hysteresis_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    v8d_direction_checker checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .outstanding (outstanding),
        .fail_count  (fail_count)
    );

    // The receiver decides afresh every cycle whether it accepts a result.
    always @(posedge aclk) begin
        m_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end

    // Builds a 16-bit coordinate from a magnitude and a sign. A positive
    // magnitude of 32768 does not fit, so it is clipped to the largest value.
    function automatic logic [15:0] to_coord(longint mag, bit neg);
        if (neg)
            return 16'(-mag);
        return (mag > 32767) ? 16'd32767 : 16'(mag);
    endfunction

    // Offers one item and returns at the edge where it is accepted. Before
    // the item, the sender may idle at random; while idle, tdata carries
    // junk so that the block cannot rely on it.
    task automatic send_item(input logic [15:0] vec_x, input logic [15:0] vec_y,
                             input dir_t prev);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 40'({$urandom, $urandom});
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, prev, vec_y, vec_x};
        do
            @(posedge aclk);
        while (!s_tready);
    endtask

    // Stops sending until every expected result has come back. The item
    // count from the scoreboard is registered and lags, hence the first wait.
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0)
            @(posedge aclk);
    endtask

    // Random items. Most vectors sit within one step of a band edge, which is
    // where the sticky bands and the exact ties live; the rest are fully
    // random words or tiny vectors around the origin.
    task automatic send_random_items(input int count);
        int unsigned     style;
        longint          mag_x;
        longint          mag_y;
        longint unsigned tan_q16;
        logic [15:0]     vec_x;
        logic [15:0]     vec_y;
        for (int n = 0; n < count; n++) begin
            style = $urandom_range(7);
            if (style < 2) begin
                vec_x = 16'($urandom);
                vec_y = 16'($urandom);
            end else if (style < 3) begin
                vec_x = 16'(int'($urandom_range(40)) - 20);
                vec_y = 16'(int'($urandom_range(40)) - 20);
            end else begin
                case ($urandom_range(5))
                    0: tan_q16 = 17560;
                    1: tan_q16 = 27146;
                    2: tan_q16 = 37837;
                    3: tan_q16 = 113512;
                    4: tan_q16 = 158218;
                    default: tan_q16 = 244584;
                endcase
                mag_x = $urandom_range(3) == 0 ? $urandom_range(64) : $urandom_range(32768);
                mag_y = longint'((unsigned'(mag_x) * tan_q16) >> 16)
                        + int'($urandom_range(2)) - 1;
                if (mag_y < 0)
                    mag_y = 0;
                if (mag_y > 32768)
                    mag_y = 32768;
                vec_x = to_coord(mag_x, 1'($urandom_range(1)));
                vec_y = to_coord(mag_y, 1'($urandom_range(1)));
            end
            send_item(vec_x, vec_y, dir_t'($urandom_range(7)));
        end
    endtask

    // One phase of random traffic with the given idle and stall rates. The
    // sender always waits for the pipeline to empty at the end of a phase.
    task automatic run_phase(input int idle_pct, input int stall_rate);
        send_idle_pct = idle_pct;
        stall_pct     = stall_rate;
        send_random_items(RANDOM_PER_PHASE);
        wait_for_drain();
    endtask

    initial begin
        // Synchronous reset, held low from time zero and released once.
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed items, sent back to back with the receiver always ready.
        // The zero vector and the zero components on either axis.
        send_item(16'd0, 16'd0, DIR_LD);
        send_item(16'd100, 16'd0, DIR_D);
        send_item(16'(-100), 16'd0, DIR_R);
        send_item(16'd0, 16'd100, DIR_L);
        send_item(16'd0, 16'(-100), DIR_R);
        // Field extremes, including the most negative value on both axes.
        send_item(16'h8000, 16'h8000, DIR_U);
        send_item(16'h7fff, 16'h8000, DIR_R);
        send_item(16'h8000, 16'h7fff, DIR_RU);
        send_item(16'h8000, 16'd0, DIR_RU);
        send_item(16'd0, 16'h8000, DIR_D);
        send_item(16'h7fff, 16'h7fff, DIR_R);
        // Vectors lying exactly on an edge; the previous direction is chosen
        // so that counting the tie on the wrong side changes the answer.
        send_item(16'd8192, 16'd2195, DIR_RD);
        send_item(16'h8000, 16'd13573, DIR_U);
        send_item(16'd8192, 16'd14189, DIR_D);
        send_item(16'd8192, 16'd30573, DIR_RD);
        // The diagonal and vertical pure bands and both sticky bands, kept and split.
        send_item(16'd100, 16'd36, DIR_R);
        send_item(16'd100, 16'd36, DIR_RD);
        send_item(16'd100, 16'd36, DIR_U);
        send_item(16'(-100), 16'd51, DIR_R);
        send_item(16'(-100), 16'(-100), DIR_L);
        send_item(16'(-100), 16'(-214), DIR_LU);
        send_item(16'(-100), 16'(-275), DIR_R);
        send_item(16'd100, 16'(-275), DIR_RU);
        send_item(16'd10, 16'(-900), DIR_LU);
        // The sender holds off here until every directed result is back.
        wait_for_drain();

        // Random traffic: no idling, a lazy sender, a slow receiver, then both.
        run_phase(0, 0);
        run_phase(77, 0);
        run_phase(0, 77);
        run_phase(21, 21);

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0 && outstanding == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog: ends a run that hangs and reports a failure.
    initial begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/v8d_pkg.sv
rtl/v8d_sector.sv
rtl/v8d_pick.sv
rtl/vector_to_eight_direction_hysteresis_top.sv
rtl/v8d_checker.sv
sim/v8d_direction_checker.sv
sim/vector_to_eight_direction_hysteresis_top_test.sv
